// File: hw/rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the LRU buffer pool
// Field widths, command codes and default sizes.
// ----------------------------------------------------------------------------
package lbp_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int FILE_TAG_BITS_DEF = 8;
    localparam int BLOCK_BITS_DEF = 31;

    localparam int CMD_W = 2;
    localparam int SEL_W = 4;
    localparam int FREED_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INVAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIRTY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PIN = 2'd3;
endpackage

// File: hw/rtl/lbp_req_if.sv
// ----------------------------------------------------------------------------
// lbp_req_if: request channel of the buffer pool
// Valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface lbp_req_if
    import lbp_pkg::*;
#(
    parameter int FILE_TAG_BITS = FILE_TAG_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [FILE_TAG_BITS-1:0] file_tag;
    logic [BLOCK_BITS-1:0]    block_num;
    logic [SEL_W-1:0]         slot_sel;
    logic                     mark_value;

    modport source (output valid, cmd, file_tag, block_num, slot_sel, mark_value,
                    input ready);
    modport sink (input valid, cmd, file_tag, block_num, slot_sel, mark_value,
                  output ready);
endinterface

// File: hw/rtl/lbp_rsp_if.sv
// ----------------------------------------------------------------------------
// lbp_rsp_if: response channel of the buffer pool
// Valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface lbp_rsp_if
    import lbp_pkg::*;
#(
    parameter int FILE_TAG_BITS = FILE_TAG_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [SEL_W-1:0]         slot;
    logic                     hit;
    logic                     fetch_needed;
    logic                     writeback_needed;
    logic [FILE_TAG_BITS-1:0] old_file;
    logic [BLOCK_BITS-1:0]    old_block;
    logic                     no_victim;
    logic [FREED_W-1:0]       freed_count;

    modport source (output valid, slot, hit, fetch_needed, writeback_needed, old_file,
                    old_block, no_victim, freed_count, input ready);
    modport sink (input valid, slot, hit, fetch_needed, writeback_needed, old_file,
                  old_block, no_victim, freed_count, output ready);
endinterface

// File: hw/rtl/lru_buffer_pool_with_pinning.sv
// ----------------------------------------------------------------------------
// lru_buffer_pool_with_pinning: fully associative slot manager with LRU order
// Lookup, file invalidation and dirty/pin marks, one slot examined per cycle.
// ----------------------------------------------------------------------------
// Steps after accept: a mark is applied and its result registered on accept; a
// lookup scans up to the hit, then makes a rank update pass; a miss scans all
// slots, searches for a victim and updates ranks, or ends at no victim; an
// invalidate scans all slots, with a rank pass per freed slot. Throughput: one
// request at a time; ready returns the cycle after the result is taken.
// Reset clears all valid, dirty and pin bits and the ranks at once.
module lru_buffer_pool_with_pinning
    import lbp_pkg::*;
#(
    parameter int FILE_TAG_BITS = FILE_TAG_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    lbp_req_if.sink   req,
    lbp_rsp_if.source rsp
);
    localparam int SLOTS = SLOTS_DEF;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1; // hit search / invalid-file search
    localparam logic [2:0] ST_VICT   = 3'd2; // free slot or victim search
    localparam logic [2:0] ST_AGE    = 3'd3; // rank update pass
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [FILE_TAG_BITS-1:0] tag_file_reg [SLOTS];
    logic [BLOCK_BITS-1:0]    tag_block_reg [SLOTS];
    logic [SLOTS-1:0]         valid_reg, dirty_reg, pin_reg;
    logic [IW-1:0]            rank_reg [SLOTS];

    logic [2:0]               state_reg;
    logic [IW-1:0]            idx_reg;
    logic [CMD_W-1:0]         cmd_reg;
    logic [FILE_TAG_BITS-1:0] file_reg;
    logic [BLOCK_BITS-1:0]    blk_reg;
    logic [IW-1:0]            tgt_reg;     // slot found
    logic                     found_reg;
    logic                     free_reg;    // found slot was free
    logic                     hitm_reg;    // age mode: 1 = hit/evict, 0 = fill, inval = dec
    logic [IW-1:0]            r_reg;       // old rank of target
    logic [CW-1:0]            freed_reg;
    logic                     last_scan;
    logic                     out_v_reg;

    assign last_scan = (idx_reg == IW'(SLOTS - 1));
    assign req.ready = (state_reg == ST_IDLE) && !out_v_reg;
    assign rsp.valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            valid_reg <= '0;
            dirty_reg <= '0;
            pin_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_reg[i] <= '0;
                tag_file_reg[i] <= '0;
                tag_block_reg[i] <= '0;
            end
            idx_reg <= '0;
            cmd_reg <= CMD_LOOKUP;
            file_reg <= '0;
            blk_reg <= '0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
            hitm_reg <= 1'b0;
            freed_reg <= '0;
            tgt_reg <= '0;
            r_reg <= '0;
            rsp.slot <= '0;
            rsp.hit <= 1'b0;
            rsp.fetch_needed <= 1'b0;
            rsp.writeback_needed <= 1'b0;
            rsp.old_file <= '0;
            rsp.old_block <= '0;
            rsp.no_victim <= 1'b0;
            rsp.freed_count <= '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        cmd_reg <= req.cmd;
                        file_reg <= req.file_tag;
                        blk_reg <= req.block_num;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        freed_reg <= '0;
                        if (req.cmd == CMD_DIRTY || req.cmd == CMD_PIN)
                        begin
                            rsp.slot <= req.slot_sel;
                            rsp.hit <= 1'b0;
                            rsp.fetch_needed <= 1'b0;
                            rsp.writeback_needed <= 1'b0;
                            rsp.old_file <= '0;
                            rsp.old_block <= '0;
                            rsp.no_victim <= 1'b0;
                            rsp.freed_count <= '0;
                            if (32'(req.slot_sel) < SLOTS && valid_reg[IW'(req.slot_sel)])
                            begin
                                if (req.cmd == CMD_DIRTY)
                                    dirty_reg[IW'(req.slot_sel)] <= req.mark_value;
                                else
                                    pin_reg[IW'(req.slot_sel)] <= req.mark_value;
                            end
                            out_v_reg <= 1'b1;
                        end
                        else
                            state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // one tag compare per cycle
                    if (valid_reg[idx_reg] && tag_file_reg[idx_reg] == file_reg &&
                        (cmd_reg == CMD_INVAL || tag_block_reg[idx_reg] == blk_reg))
                    begin
                        tgt_reg <= idx_reg;
                        r_reg <= rank_reg[idx_reg];
                        hitm_reg <= 1'b1;
                        if (cmd_reg == CMD_INVAL)
                        begin
                            valid_reg[idx_reg] <= 1'b0;
                            dirty_reg[idx_reg] <= 1'b0;
                            pin_reg[idx_reg] <= 1'b0;
                            rank_reg[idx_reg] <= '0;
                            tag_file_reg[idx_reg] <= '0;
                            tag_block_reg[idx_reg] <= '0;
                            freed_reg <= freed_reg + CW'(1);
                        end
                        found_reg <= 1'b1;
                        idx_reg <= '0;
                        state_reg <= ST_AGE;
                    end
                    else if (last_scan)
                    begin
                        idx_reg <= '0;
                        if (cmd_reg == CMD_INVAL)
                        begin
                            rsp.slot <= '0;
                            rsp.hit <= 1'b0;
                            rsp.fetch_needed <= 1'b0;
                            rsp.writeback_needed <= 1'b0;
                            rsp.old_file <= '0;
                            rsp.old_block <= '0;
                            rsp.no_victim <= 1'b0;
                            rsp.freed_count <= FREED_W'(freed_reg);
                            out_v_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_VICT;
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                ST_VICT:
                begin
                    // free slot wins at once; otherwise keep oldest unpinned
                    if (!valid_reg[idx_reg] && !(found_reg && free_reg))
                    begin
                        tgt_reg <= idx_reg;
                        found_reg <= 1'b1;
                        free_reg <= 1'b1;
                    end
                    else if (!(found_reg && free_reg) && !pin_reg[idx_reg] &&
                             (!found_reg || rank_reg[idx_reg] > rank_reg[tgt_reg]))
                    begin
                        tgt_reg <= idx_reg;
                        found_reg <= 1'b1;
                        free_reg <= 1'b0;
                    end
                    if (last_scan)
                        state_reg <= ST_DONE;
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                ST_DONE:
                begin
                    rsp.hit <= 1'b0;
                    rsp.freed_count <= '0;
                    rsp.writeback_needed <= 1'b0;
                    rsp.old_file <= '0;
                    rsp.old_block <= '0;
                    if (!found_reg)
                    begin
                        rsp.slot <= '0;
                        rsp.fetch_needed <= 1'b0;
                        rsp.no_victim <= 1'b1;
                        out_v_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        rsp.slot <= SEL_W'(tgt_reg);
                        rsp.fetch_needed <= 1'b1;
                        rsp.no_victim <= 1'b0;
                        if (!free_reg && dirty_reg[tgt_reg])
                        begin
                            rsp.writeback_needed <= 1'b1;
                            rsp.old_file <= tag_file_reg[tgt_reg];
                            rsp.old_block <= tag_block_reg[tgt_reg];
                        end
                        r_reg <= rank_reg[tgt_reg];
                        hitm_reg <= !free_reg;
                        valid_reg[tgt_reg] <= 1'b1;
                        tag_file_reg[tgt_reg] <= file_reg;
                        tag_block_reg[tgt_reg] <= blk_reg;
                        dirty_reg[tgt_reg] <= 1'b0;
                        pin_reg[tgt_reg] <= 1'b0;
                        idx_reg <= '0;
                        state_reg <= ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    // one rank compare and step per cycle
                    if (idx_reg != tgt_reg && valid_reg[idx_reg])
                    begin
                        if (cmd_reg == CMD_INVAL)
                        begin
                            if (rank_reg[idx_reg] > r_reg)
                                rank_reg[idx_reg] <= rank_reg[idx_reg] - IW'(1);
                        end
                        else if (!hitm_reg || rank_reg[idx_reg] < r_reg)
                            rank_reg[idx_reg] <= rank_reg[idx_reg] + IW'(1);
                    end
                    if (last_scan)
                    begin
                        if (cmd_reg == CMD_INVAL)
                        begin
                            // resume the search after the freed slot
                            if (tgt_reg == IW'(SLOTS - 1))
                            begin
                                idx_reg <= IW'(SLOTS - 1);
                                state_reg <= ST_SCAN;
                            end
                            else
                            begin
                                idx_reg <= tgt_reg + IW'(1);
                                state_reg <= ST_SCAN;
                            end
                        end
                        else
                        begin
                            rank_reg[tgt_reg] <= '0;
                            out_v_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                default: state_reg <= ST_IDLE;
            endcase
            // hit result is fixed when the hit is found
            if (state_reg == ST_SCAN && cmd_reg == CMD_LOOKUP && valid_reg[idx_reg] &&
                tag_file_reg[idx_reg] == file_reg && tag_block_reg[idx_reg] == blk_reg)
            begin
                rsp.slot <= SEL_W'(idx_reg);
                rsp.hit <= 1'b1;
                rsp.fetch_needed <= 1'b0;
                rsp.writeback_needed <= 1'b0;
                rsp.old_file <= '0;
                rsp.old_block <= '0;
                rsp.no_victim <= 1'b0;
                rsp.freed_count <= '0;
                free_reg <= 1'b0;
            end
        end
    end

    // Note: last-slot freed during invalidate re-enters SCAN on a now-invalid slot,
    // which then finishes the walk.

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !req.ready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !rsp.ready |=> out_v_reg)
        else $error("result dropped");
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> !req.ready)
        else $error("accepted with pending result");
    a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(freed_reg) <= SLOTS)
        else $error("freed count overflow");
endmodule
